>>> design/kspsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kspsl_pkg
// Shared constants and types for the keyed slot pool with a sorted list.
// ----------------------------------------------------------------------------
package kspsl_pkg;
  localparam int POOL_SIZE_DEF = 64;
  localparam int KEY_BITS_DEF  = 16;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_EXPIRE  = 2'd1;
  localparam logic [1:0] OP_RECYCLE = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_INACTIVE = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SRCH = 4'b0010,
    S_RUN  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic ins;      // insert step of add
    logic cmp;      // compaction step of recycle
  } cell_cmd_t;
endpackage

>>> design/kspsl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kspsl_cell
// One list position: holds a slot number, its key and its dead flag.
// ----------------------------------------------------------------------------
module kspsl_cell import kspsl_pkg::*; #(
  parameter int SW = 6,
  parameter int KW = 16
) (
  input  logic          clk,
  input  cell_cmd_t     cmd,
  input  logic          occ,       // this position is inside the list
  input  logic          left_gt,   // left neighbor holds a key above the new one
  input  logic          left_occ,
  input  logic [SW-1:0] left_slot,
  input  logic [KW-1:0] left_key,
  input  logic          left_dead,
  input  logic [SW-1:0] new_slot,
  input  logic [KW-1:0] new_key,
  input  logic          shift_in,  // compaction: take the value from the right
  input  logic [SW-1:0] right_slot,
  input  logic [KW-1:0] right_key,
  input  logic          right_dead,
  input  logic          set_dead,
  output logic          gt,
  output logic [SW-1:0] slot,
  output logic [KW-1:0] key,
  output logic          dead
);
  logic [SW-1:0] slot_r;
  logic [KW-1:0] key_r;
  logic          dead_r;

  assign gt   = occ && (key_r > new_key);
  assign slot = slot_r;
  assign key  = key_r;
  assign dead = dead_r;

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (left_gt && left_occ) begin
        slot_r <= left_slot;
        key_r  <= left_key;
        dead_r <= left_dead;
      end else if (gt || !occ) begin
        slot_r <= new_slot;
        key_r  <= new_key;
        dead_r <= 1'b0;
      end
    end else if (cmd.cmp && shift_in) begin
      slot_r <= right_slot;
      key_r  <= right_key;
      dead_r <= right_dead;
    end else if (set_dead) begin
      dead_r <= 1'b1;
    end
  end
endmodule

>>> design/keyed_slot_pool_sorted_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_slot_pool_sorted_list
// Slot pool with next-fit allocation and a key-sorted list held in a row of
// cells.
//
//   channel  ports                                            direction
//   in       in_valid in_stall opcode key slot_index position  input
//   out      out_valid out_stall status slot key counts        output
//
// From acceptance, add passes through the next-fit search, which steps past each
// listed slot, then the insert step and the output state.
// Add to a full pool goes straight to the output state. Read and expire pass
// through the run and output states. Recycle removes one dead entry per step.
// Reset clears the list length, hint and per-slot flags.
// A result waits in the output register while out_stall is high, and no new
// request is accepted until it has left.
// ----------------------------------------------------------------------------
module keyed_slot_pool_sorted_list import kspsl_pkg::*; #(
  parameter int POOL_SIZE = POOL_SIZE_DEF,
  parameter int KEY_BITS  = KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_texture_key,
  input  logic [5:0]  in_slot_index,
  input  logic [5:0]  in_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [5:0]  out_result_slot,
  output logic [15:0] out_result_key,
  output logic [6:0]  out_active_count,
  output logic [6:0]  out_removed_count
);
  localparam int SW = $clog2(POOL_SIZE);
  localparam int CW = $clog2(POOL_SIZE + 1);
  localparam int KW = KEY_BITS;

  state_t        st_r;
  logic [1:0]    op_r;
  logic [KW-1:0] key_r;
  logic [5:0]    sidx_r;
  logic [5:0]    pos_r;
  logic [CW-1:0] len_r;
  logic [SW-1:0] hint_r;
  logic [CW-1:0] rem_r;
  logic [POOL_SIZE-1:0] inl_r;
  logic [POOL_SIZE-1:0] dead_slot_r;

  logic [1:0]  o_status_r;
  logic [5:0]  o_slot_r;
  logic [15:0] o_key_r;
  logic [6:0]  o_act_r;
  logic [6:0]  o_rem_r;
  logic        o_valid_r;

  cell_cmd_t cmd;
  logic [POOL_SIZE-1:0] c_gt, c_dead, c_occ, c_shift, c_set, c_first;
  logic [SW-1:0] c_slot [POOL_SIZE];
  logic [KW-1:0] c_key  [POOL_SIZE];
  logic [POOL_SIZE-1:0] dead_seen;
  logic [SW-1:0] free_slot;

  logic [KW-1:0] in_key;
  logic [SW-1:0] pos_i;
  logic [SW-1:0] sidx_i;
  logic          any_dead;
  logic          pos_ok;
  logic          sidx_ok;

  assign in_key = in_texture_key[KW-1:0];
  assign pos_i  = pos_r[SW-1:0];
  assign sidx_i = sidx_r[SW-1:0];
  assign pos_ok  = (7'(pos_r) < 7'(len_r));
  assign sidx_ok = (sidx_r < 6'(POOL_SIZE)) || (POOL_SIZE >= 64);
  assign any_dead = |(c_dead & c_occ);

  assign in_stall  = (st_r != S_IDLE) || o_valid_r;
  assign out_valid = o_valid_r;
  assign out_status = o_status_r;
  assign out_result_slot = o_slot_r;
  assign out_result_key = o_key_r;
  assign out_active_count = o_act_r;
  assign out_removed_count = o_rem_r;

  always_comb begin
    cmd = '0;
    cmd.ins = (st_r == S_RUN) && (op_r == OP_ADD);
    cmd.cmp = (st_r == S_RUN) && (op_r == OP_RECYCLE) && any_dead;
  end

  for (genvar g = 0; g < POOL_SIZE; g++) begin : g_cell
    localparam int L = (g == 0) ? 0 : g - 1;
    localparam int R = (g == POOL_SIZE - 1) ? g : g + 1;
    assign c_occ[g] = (CW'(g) < len_r);
    if (g == 0) begin : g_first
      assign dead_seen[g] = c_dead[g] & c_occ[g];
      assign c_first[g] = dead_seen[g];
    end else begin : g_rest
      assign dead_seen[g] = dead_seen[g-1] | (c_dead[g] & c_occ[g]);
      assign c_first[g] = dead_seen[g] & ~dead_seen[g-1];
    end
    assign c_shift[g] = dead_seen[g];
    assign c_set[g] = (st_r == S_RUN) && (op_r == OP_EXPIRE) && sidx_ok &&
                      c_occ[g] && (c_slot[g] == sidx_i) && inl_r[sidx_i] &&
                      !dead_slot_r[sidx_i];
    kspsl_cell #(.SW(SW), .KW(KW)) u_cell (
      .clk(clk), .cmd(cmd), .occ(c_occ[g]),
      .left_gt((g == 0) ? 1'b0 : c_gt[L]),
      .left_occ((g == 0) ? 1'b0 : c_occ[L]),
      .left_slot(c_slot[L]), .left_key(c_key[L]), .left_dead(c_dead[L]),
      .new_slot(hint_r), .new_key(key_r),
      .shift_in(c_shift[g]),
      .right_slot(c_slot[R]), .right_key(c_key[R]), .right_dead(c_dead[R]),
      .set_dead(c_set[g]),
      .gt(c_gt[g]), .slot(c_slot[g]), .key(c_key[g]), .dead(c_dead[g])
    );
  end

  // The slot of the leftmost dead entry, which one compaction step frees.
  always_comb begin
    free_slot = '0;
    for (int k = 0; k < POOL_SIZE; k++) begin
      free_slot = free_slot | (c_slot[k] & {SW{c_first[k]}});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      len_r <= '0;
      hint_r <= '0;
      inl_r <= '0;
      dead_slot_r <= '0;
      o_valid_r <= 1'b0;
    end else begin
      if (o_valid_r && !out_stall) o_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            op_r <= in_opcode;
            key_r <= in_key;
            sidx_r <= in_slot_index;
            pos_r <= in_position;
            rem_r <= '0;
            if (in_opcode == OP_ADD && len_r != CW'(POOL_SIZE)) begin
              st_r <= S_SRCH;
            end else if (in_opcode == OP_ADD) begin
              o_status_r <= ST_FULL;
              o_slot_r <= '0;
              st_r <= S_OUT;
            end else begin
              st_r <= S_RUN;
            end
          end
        end
        S_SRCH: begin
          if (!inl_r[hint_r]) st_r <= S_RUN;
          else hint_r <= (hint_r == SW'(POOL_SIZE - 1)) ? '0 : hint_r + 1'b1;
        end
        S_RUN: begin
          unique case (op_r)
            OP_ADD: begin
              inl_r[hint_r] <= 1'b1;
              dead_slot_r[hint_r] <= 1'b0;
              len_r <= len_r + 1'b1;
              o_slot_r <= 6'(hint_r);
              hint_r <= (hint_r == SW'(POOL_SIZE - 1)) ? '0 : hint_r + 1'b1;
              o_status_r <= ST_OK;
              st_r <= S_OUT;
            end
            OP_EXPIRE: begin
              o_slot_r <= '0;
              if (sidx_ok && inl_r[sidx_i] && !dead_slot_r[sidx_i]) begin
                dead_slot_r[sidx_i] <= 1'b1;
                o_status_r <= ST_OK;
              end else begin
                o_status_r <= ST_INACTIVE;
              end
              st_r <= S_OUT;
            end
            OP_RECYCLE: begin
              o_slot_r <= '0;
              o_status_r <= ST_OK;
              if (any_dead) begin
                inl_r[free_slot] <= 1'b0;
                dead_slot_r[free_slot] <= 1'b0;
                len_r <= len_r - 1'b1;
                rem_r <= rem_r + 1'b1;
              end else begin
                st_r <= S_OUT;
              end
            end
            default: begin
              st_r <= S_OUT;
            end
          endcase
        end
        default: begin
          if (!o_valid_r) begin
            o_valid_r <= 1'b1;
            o_act_r <= 7'(len_r);
            o_rem_r <= (op_r == OP_RECYCLE) ? 7'(rem_r) : 7'd0;
            if (op_r == OP_READ) begin
              if (pos_ok) begin
                o_status_r <= ST_OK;
                o_slot_r <= 6'(c_slot[pos_i]);
                o_key_r <= 16'(c_key[pos_i]);
              end else begin
                o_status_r <= ST_RANGE;
                o_slot_r <= '0;
                o_key_r <= '0;
              end
            end else begin
              o_key_r <= '0;
            end
            st_r <= S_IDLE;
          end
        end
      endcase
    end
  end
endmodule

>>> test/tb_keyed_slot_pool_sorted_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_slot_pool_sorted_list
// Drives add, expire, recycle and read requests into the slot pool and checks
// every result against a behavioral copy of the pool and its sorted list.
// A directed table, fill and expiry runs come first, then random traffic in four phases.
// ----------------------------------------------------------------------------
module tb_keyed_slot_pool_sorted_list;
  import kspsl_pkg::*;

  localparam int NSLOT = 64;
  localparam int WATCHDOG = 20000;
  localparam int QDEPTH = 16;
  localparam int NROWS = 24;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] key;
    logic [5:0]  slot;
    logic [5:0]  pos;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [15:0] key;
    logic [6:0]  active;
    logic [6:0]  removed;
  } outcome_t;

  typedef struct {
    request_t req;
    logic     typed;
    outcome_t want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  logic [15:0] in_texture_key = '0;
  logic [5:0] in_slot_index = '0;
  logic [5:0] in_position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [5:0] out_result_slot;
  logic [15:0] out_result_key;
  logic [6:0] out_active_count;
  logic [6:0] out_removed_count;

  keyed_slot_pool_sorted_list dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state.
  bit          listed [NSLOT];
  bit          dead [NSLOT];
  logic [15:0] slot_key [NSLOT];
  logic [5:0]  order [NSLOT];
  int          length;
  int          hint;

  outcome_t outcome_fifo [QDEPTH];
  int fifo_wr = 0;
  int fifo_rd = 0;
  table_row_t rows [NROWS];
  int n_rows = 0;
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct;
  int stall_pct;
  bit hold_off;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic add_row(input request_t r, input logic typed, input outcome_t want);
    rows[n_rows] = '{r, typed, want};
    n_rows++;
  endtask

  function automatic outcome_t pool_apply(request_t r);
    outcome_t o;
    int i;
    int lo;
    o = '0;
    case (r.op)
      OP_ADD: begin
        if (length >= NSLOT) begin
          o.status = ST_FULL;
        end else begin
          i = hint;
          while (listed[i]) i = (i + 1) % NSLOT;
          listed[i] = 1;
          dead[i] = 0;
          slot_key[i] = r.key;
          hint = (i + 1) % NSLOT;
          lo = 0;
          while (lo < length && slot_key[order[lo]] <= r.key) lo++;
          for (int j = length; j > lo; j--) order[j] = order[j-1];
          order[lo] = 6'(i);
          length++;
          o.slot = 6'(i);
        end
      end
      OP_EXPIRE: begin
        if (!listed[r.slot] || dead[r.slot]) o.status = ST_INACTIVE;
        else dead[r.slot] = 1;
      end
      OP_RECYCLE: begin
        lo = 0;
        for (int k = 0; k < length; k++) begin
          if (dead[order[k]]) begin
            dead[order[k]] = 0;
            listed[order[k]] = 0;
            o.removed++;
          end else begin
            order[lo] = order[k];
            lo++;
          end
        end
        length = lo;
      end
      default: begin
        if (r.pos >= length) begin
          o.status = ST_RANGE;
        end else begin
          o.slot = order[r.pos];
          o.key = slot_key[order[r.pos]];
        end
      end
    endcase
    o.active = 7'(length);
    return o;
  endfunction

  task automatic send_request(input request_t r, input logic typed, input outcome_t want);
    outcome_t p;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= r.op;
    in_texture_key <= r.key;
    in_slot_index <= r.slot;
    in_position <= r.pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = pool_apply(r);
    outcome_fifo[fifo_wr % QDEPTH] = typed ? want : p;
    fifo_wr++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (fifo_wr != fifo_rd) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  function automatic request_t random_request();
    request_t r;
    int pick;
    r.key = 16'($urandom());
    if ($urandom_range(3) == 0) r.key = 16'($urandom_range(7));
    r.slot = 6'($urandom());
    r.pos = 6'($urandom());
    pick = $urandom_range(99);
    if (pick < 45) r.op = OP_ADD;
    else if (pick < 70) r.op = OP_EXPIRE;
    else if (pick < 78) r.op = OP_RECYCLE;
    else r.op = OP_READ;
    if (r.op == OP_EXPIRE && length > 0 && $urandom_range(3) != 0)
      r.slot = order[$urandom_range(length - 1)];
    if (r.op == OP_READ && length > 0 && $urandom_range(3) != 0)
      r.pos = 6'($urandom_range(length - 1));
    return r;
  endfunction

  // Result checker and receiver stall.
  always @(posedge clk) begin
    outcome_t w;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        idle_cycles <= 0;
        if (fifo_wr == fifo_rd) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          w = outcome_fifo[fifo_rd % QDEPTH];
          fifo_rd++;
          if (out_status !== w.status) report_mismatch("status", out_status, w.status);
          if (out_result_slot !== w.slot) report_mismatch("slot", out_result_slot, w.slot);
          if (out_result_key !== w.key) report_mismatch("key", out_result_key, w.key);
          if (out_active_count !== w.active)
            report_mismatch("active_count", out_active_count, w.active);
          if (out_removed_count !== w.removed)
            report_mismatch("removed_count", out_removed_count, w.removed);
        end
      end else if (in_valid && !in_stall) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      out_stall <= hold_off || (stall_pct > 0 && $urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    request_t rq;
    outcome_t o;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off = 0;
    length = 0;
    hint = 0;
    foreach (listed[i]) begin
      listed[i] = 0;
      dead[i] = 0;
      slot_key[i] = '0;
      order[i] = '0;
    end

    // Directed table; typed rows are the obvious cases.
    o = '0; o.status = ST_RANGE;
    add_row('{OP_READ, 16'h0, 6'd0, 6'd0}, 1'b1, o);
    o = '0; o.status = ST_INACTIVE;
    add_row('{OP_EXPIRE, 16'h0, 6'd63, 6'd0}, 1'b1, o);
    o = '0;
    add_row('{OP_RECYCLE, 16'h0, 6'd0, 6'd0}, 1'b1, o);
    o = '0; o.active = 1;
    add_row('{OP_ADD, 16'hFFFF, 6'd0, 6'd0}, 1'b1, o);
    add_row('{OP_ADD, 16'h0000, 6'd0, 6'd0}, 1'b0, '0);
    add_row('{OP_ADD, 16'h8000, 6'd0, 6'd0}, 1'b0, '0);
    add_row('{OP_ADD, 16'h8000, 6'd0, 6'd0}, 1'b0, '0);
    add_row('{OP_ADD, 16'h5555, 6'd0, 6'd0}, 1'b0, '0);
    add_row('{OP_READ, 16'h0, 6'd0, 6'd0}, 1'b0, '0);
    add_row('{OP_READ, 16'h0, 6'd0, 6'd4}, 1'b0, '0);
    add_row('{OP_READ, 16'h0, 6'd0, 6'd63}, 1'b0, '0);
    add_row('{OP_EXPIRE, 16'h0, 6'd2, 6'd0}, 1'b0, '0);
    add_row('{OP_EXPIRE, 16'h0, 6'd2, 6'd0}, 1'b0, '0);
    add_row('{OP_READ, 16'h0, 6'd0, 6'd2}, 1'b0, '0);
    add_row('{OP_ADD, 16'hAAAA, 6'd0, 6'd0}, 1'b0, '0);
    add_row('{OP_EXPIRE, 16'h0, 6'd0, 6'd0}, 1'b0, '0);
    add_row('{OP_RECYCLE, 16'h0, 6'd0, 6'd0}, 1'b0, '0);
    add_row('{OP_READ, 16'h0, 6'd0, 6'd3}, 1'b0, '0);
    add_row('{OP_ADD, 16'h1234, 6'd0, 6'd0}, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < n_rows; i++) send_request(rows[i].req, rows[i].typed, rows[i].want);
    drain();

    // Fill the pool to the top and overflow it, with the receiver held off.
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      begin
        for (int k = 0; k < 70; k++) begin
          rq = random_request();
          rq.op = OP_ADD;
          send_request(rq, 1'b0, '0);
        end
      end
    join
    drain();
    for (int k = 0; k < NSLOT; k++) begin
      rq = random_request();
      rq.op = OP_EXPIRE;
      rq.slot = 6'(k);
      send_request(rq, 1'b0, '0);
    end
    rq.op = OP_RECYCLE;
    send_request(rq, 1'b0, '0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 82 : 24) : 0;
      stall_pct = (phase == 2) ? 82 : ((phase == 3) ? 24 : 0);
      for (int k = 0; k < 170; k++) send_request(random_request(), 1'b0, '0);
    end
    send_idle_pct = 0;
    stall_pct = 0;
    drain();
    repeat (150) @(posedge clk);

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
